// ===== rtl/tsva_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsva_pkg
// Shared types and constants of the triple sensor voter: status codes,
// register indexes, the constant reciprocal for the three-way mean and the
// item tag that travels down the normalizing divider.
// ---------------------------------------------------------------------------
package tsva_pkg;

	// Status codes of one vote.
	typedef enum logic [2:0] {
		ST_ALL_AGREE = 3'd0,
		ST_A_BAD     = 3'd1,
		ST_B_BAD     = 3'd2,
		ST_C_BAD     = 3'd3,
		ST_TOTAL     = 3'd4
	} vote_status_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_THROTTLE_FS = 2'd0;
	localparam logic [1:0] REG_PEDAL_FS    = 2'd1;

	// Full scale reset value and the saturated fraction (1.0 in 1/32768 units).
	localparam logic [15:0] FULL_SCALE_RST = 16'hFFFF;
	localparam logic [15:0] FRAC_ONE       = 16'h8000;

	// Number of quotient bits below 1.0, one per divider stage.
	localparam int DIV_BITS = 15;

	// x / 3 == (x * RECIP3) >> RECIP3_SHIFT, exact for x below 2**19.
	localparam logic [17:0] RECIP3       = 18'd174763;
	localparam int          RECIP3_SHIFT = 19;

	// Status and mean of one item, carried alongside the divider.
	typedef struct packed {
		vote_status_t status;
		logic [15:0]  mean;
	} tsva_tag_t;

endpackage

// ===== rtl/tsva_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsva_in_if / tsva_out_if
// Valid/ready channels of the voter: three raw readings with a sensor kind
// in, and the vote status, mean and normalized level out.
// ---------------------------------------------------------------------------
interface tsva_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] reading_a;
	logic [15:0] reading_b;
	logic [15:0] reading_c;
	logic        sensor_kind;

	modport source(output valid, output reading_a, output reading_b,
		output reading_c, output sensor_kind, input ready);
	modport sink(input valid, input reading_a, input reading_b,
		input reading_c, input sensor_kind, output ready);
endinterface

interface tsva_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  vote_status;
	logic [15:0] mean_reading;
	logic [15:0] normalized_level;

	modport source(output valid, output vote_status, output mean_reading,
		output normalized_level, input ready);
	modport sink(input valid, input vote_status, input mean_reading,
		input normalized_level, output ready);
endinterface

// ===== rtl/tsva_frac_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsva_frac_div
// Pipelined restoring divider that turns the mean into a fraction of the
// full scale: floor(mean * 32768 / full), saturated at 32768. One quotient
// bit per stage; the last stage is the output register of the block.
// ---------------------------------------------------------------------------
module tsva_frac_div
	import tsva_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  tsva_tag_t   in_tag,
	input  logic [15:0] full,
	output logic        out_vld,
	output tsva_tag_t   out_tag,
	output logic [15:0] out_level
);

	logic [DIV_BITS:0]     vld_s;
	tsva_tag_t             tag_s  [DIV_BITS+1];
	logic [15:0]           full_s [DIV_BITS+1];
	logic [15:0]           rem_s  [DIV_BITS+1];
	logic [DIV_BITS-1:0]   quo_s  [DIV_BITS+1];
	logic [DIV_BITS:0]     sat_s;

	// Valid bits of all stages advance together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DIV_BITS-1:0], in_vld};
		end
	end

	// Entry stage: a mean at or above full scale saturates, otherwise the
	// remainder starts at the mean and is always below full scale.
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0]  <= in_tag;
			full_s[0] <= full;
			rem_s[0]  <= in_tag.mean;
			quo_s[0]  <= '0;
			sat_s[0]  <= (in_tag.mean >= full);
		end
	end

	// One shift, compare and subtract per stage.
	for (genvar k = 1; k <= DIV_BITS; k++) begin : g_step
		logic [16:0] rem2;
		logic        ge;

		assign rem2 = {rem_s[k-1], 1'b0};
		assign ge   = (rem2 >= {1'b0, full_s[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k]  <= tag_s[k-1];
				full_s[k] <= full_s[k-1];
				sat_s[k]  <= sat_s[k-1];
				quo_s[k]  <= {quo_s[k-1][DIV_BITS-2:0], ge};
				rem_s[k]  <= ge ? 16'(rem2 - {1'b0, full_s[k-1]}) : rem2[15:0];
			end
		end
	end

	assign out_vld = vld_s[DIV_BITS];
	assign out_tag = tag_s[DIV_BITS];

	// Total failure forces zero; saturation gives exactly 1.0.
	always_comb begin
		if (tag_s[DIV_BITS].status == ST_TOTAL) begin
			out_level = '0;
		end else if (sat_s[DIV_BITS]) begin
			out_level = FRAC_ONE;
		end else begin
			out_level = {1'b0, quo_s[DIV_BITS]};
		end
	end

endmodule

// ===== rtl/triple_sensor_vote_average.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triple_sensor_vote_average
// Majority voter for three redundant position sensor readings: checks the
// pairwise spread against a tenth of the largest reading, averages the
// surviving readings and scales the mean against the configured full scale.
//
//   channel    | dir | payload
//   -----------+-----+------------------------------------------------------
//   sensor_in  | in  | reading_a, reading_b, reading_c, sensor_kind
//   vote_out   | out | vote_status, mean_reading, normalized_level
//   cfg_*      | in  | cfg_we, cfg_index, cfg_data (throttle/pedal full scale)
//
// One request is taken per cycle while vote_out is not stalled. It passes 19
// register stages, the three voting stages plus the 16-stage divider (an
// entry stage and one stage per quotient bit), before its result is valid.
// Reset clears the valid bits and restores both full scales to 65535.
// A stall on vote_out holds the whole pipeline in place; sensor_in is
// ready whenever the output register is empty or being taken.
// ---------------------------------------------------------------------------
module triple_sensor_vote_average
	import tsva_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tsva_in_if.sink     sensor_in,
	tsva_out_if.source  vote_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// 10 * (d + 1) <= top is the same test as d < floor(top / 10).
	function automatic logic tol_ok(input logic [15:0] d, input logic [15:0] top);
		logic [19:0] lim;
		lim = {1'b0, d, 3'b000} + {3'b000, d, 1'b0} + 20'd10;
		return lim <= {4'b0000, top};
	endfunction

	function automatic logic [15:0] abs_diff(input logic [15:0] x, input logic [15:0] y);
		return (x > y) ? (x - y) : (y - x);
	endfunction

	logic [15:0] throttle_fs_q;
	logic [15:0] pedal_fs_q;

	logic        en;
	logic        out_vld;
	tsva_tag_t   out_tag;
	logic [15:0] out_level;

	logic [15:0] top_in;

	logic         vld_s1;
	logic [15:0]  a_s1, b_s1, c_s1, top_s1, full_s1;
	logic [15:0]  dab_s1, dac_s1, dbc_s1;

	logic         ok_ab, ok_ac, ok_bc;
	logic         vld_s2;
	vote_status_t status_s2;
	logic [17:0]  sum_s2;
	logic         three_s2;
	logic [15:0]  full_s2;

	logic [35:0]  prod;
	logic         vld_s3;
	tsva_tag_t    tag_s3;
	logic [15:0]  full_s3;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_fs_q <= FULL_SCALE_RST;
			pedal_fs_q    <= FULL_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THROTTLE_FS: throttle_fs_q <= cfg_data;
				REG_PEDAL_FS:    pedal_fs_q    <= cfg_data;
				default:         ;
			endcase
		end
	end

	// The whole pipeline moves unless the output register holds a result
	// that is not being taken.
	assign en              = !out_vld || vote_out.ready;
	assign sensor_in.ready = en;

	// Valid bits of the voting stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sensor_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: largest reading, pairwise spreads and selected full scale.
	always_comb begin
		top_in = sensor_in.reading_a;
		if (sensor_in.reading_b > top_in) top_in = sensor_in.reading_b;
		if (sensor_in.reading_c > top_in) top_in = sensor_in.reading_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= sensor_in.reading_a;
			b_s1    <= sensor_in.reading_b;
			c_s1    <= sensor_in.reading_c;
			top_s1  <= top_in;
			full_s1 <= sensor_in.sensor_kind ? pedal_fs_q : throttle_fs_q;
			dab_s1  <= abs_diff(sensor_in.reading_a, sensor_in.reading_b);
			dac_s1  <= abs_diff(sensor_in.reading_a, sensor_in.reading_c);
			dbc_s1  <= abs_diff(sensor_in.reading_b, sensor_in.reading_c);
		end
	end

	// Stage 2: tolerance checks, rule priority and sum of the survivors.
	assign ok_ab = tol_ok(dab_s1, top_s1);
	assign ok_ac = tol_ok(dac_s1, top_s1);
	assign ok_bc = tol_ok(dbc_s1, top_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			full_s2 <= full_s1;
			if (ok_ab && ok_ac && ok_bc) begin
				status_s2 <= ST_ALL_AGREE;
				sum_s2    <= {2'b00, a_s1} + {2'b00, b_s1} + {2'b00, c_s1};
				three_s2  <= 1'b1;
			end else if (ok_bc) begin
				status_s2 <= ST_A_BAD;
				sum_s2    <= {2'b00, b_s1} + {2'b00, c_s1};
				three_s2  <= 1'b0;
			end else if (ok_ac) begin
				status_s2 <= ST_B_BAD;
				sum_s2    <= {2'b00, a_s1} + {2'b00, c_s1};
				three_s2  <= 1'b0;
			end else if (ok_ab) begin
				status_s2 <= ST_C_BAD;
				sum_s2    <= {2'b00, a_s1} + {2'b00, b_s1};
				three_s2  <= 1'b0;
			end else begin
				status_s2 <= ST_TOTAL;
				sum_s2    <= '0;
				three_s2  <= 1'b0;
			end
		end
	end

	// Stage 3: mean by reciprocal multiply for three readings, halving for two.
	assign prod = sum_s2 * RECIP3;

	always_ff @(posedge clk) begin
		if (en) begin
			full_s3       <= full_s2;
			tag_s3.status <= status_s2;
			tag_s3.mean   <= three_s2 ? prod[RECIP3_SHIFT +: 16] : sum_s2[16:1];
		end
	end

	// Normalizing divider, ending in the output register.
	tsva_frac_div u_frac_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_tag   (tag_s3),
		.full     (full_s3),
		.out_vld  (out_vld),
		.out_tag  (out_tag),
		.out_level(out_level)
	);

	assign vote_out.valid            = out_vld;
	assign vote_out.vote_status      = out_tag.status;
	assign vote_out.mean_reading     = out_tag.mean;
	assign vote_out.normalized_level = out_level;

endmodule
